[src/bbd_pkg.sv]
// Shared constants and types of the bounding box and diagonal block.
package bbd_pkg;

  // Default coordinate width (signed Q8.8 at sixteen bits).
  localparam int unsigned COORD_WIDTH = 16;

  // Number of axes of a vertex.
  localparam int unsigned NUM_AXES = 3;

  // Sequencer states of the diagonal unit.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SQUARE = 4'b0010,
    ST_ROOT   = 4'b0100,
    ST_DONE   = 4'b1000
  } diag_state_e;

endpackage

[src/bbd_extents.sv]
// Running per-axis minimum and maximum registers of the bounding box.
module bbd_extents #(
  parameter int unsigned COORD_WIDTH = bbd_pkg::COORD_WIDTH
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              update_i,
  input  logic                                              first_i,
  input  logic [bbd_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]     coord_i,
  output logic [bbd_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]     low_o,
  output logic [bbd_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]     high_o
);

  localparam logic [COORD_WIDTH-1:0] MaxVal = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] MinVal = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic [bbd_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] low_d, low_q;
  logic [bbd_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] high_d, high_q;

  // A first vertex loads the box; any other vertex widens it.
  always_comb begin
    low_d  = low_q;
    high_d = high_q;
    for (int a = 0; a < bbd_pkg::NUM_AXES; a++) begin
      if (first_i) begin
        low_d[a]  = coord_i[a];
        high_d[a] = coord_i[a];
      end else begin
        if ($signed(coord_i[a]) < $signed(low_q[a])) begin
          low_d[a] = coord_i[a];
        end
        if ($signed(coord_i[a]) > $signed(high_q[a])) begin
          high_d[a] = coord_i[a];
        end
      end
    end
  end

  // The box comes out of reset empty: lowest above highest.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < bbd_pkg::NUM_AXES; a++) begin
        low_q[a]  <= MaxVal;
        high_q[a] <= MinVal;
      end
    end else if (update_i) begin
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

  assign low_o  = low_q;
  assign high_o = high_q;

endmodule

[src/bbd_diag.sv]
// Sequenced diagonal unit: one multiplier for the squared spans, then a
// digit-by-digit floor square root, one result bit per cycle.
module bbd_diag #(
  parameter int unsigned COORD_WIDTH = bbd_pkg::COORD_WIDTH
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              start_i,
  input  logic                                              ack_i,
  input  logic [bbd_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]     low_i,
  input  logic [bbd_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]     high_i,
  output logic                                              idle_o,
  output logic                                              done_o,
  output logic [COORD_WIDTH:0]                              diag_o
);

  localparam int unsigned ProdW = 2 * COORD_WIDTH;
  localparam int unsigned SumW  = 2 * COORD_WIDTH + 2;
  localparam int unsigned RootW = COORD_WIDTH + 1;
  localparam int unsigned RemW  = COORD_WIDTH + 3;
  localparam int unsigned CntW  = $clog2(RootW);
  localparam logic [CntW-1:0] LastDigit = CntW'(RootW - 1);

  bbd_pkg::diag_state_e state_d, state_q;

  logic [1:0]             axis_d, axis_q;
  logic [ProdW-1:0]       prod_d, prod_q;
  logic [SumW-1:0]        acc_d, acc_q;
  logic [RemW-1:0]        rem_d, rem_q;
  logic [RootW-1:0]       root_d, root_q;
  logic [CntW-1:0]        cnt_d, cnt_q;

  logic [COORD_WIDTH-1:0] span_lo, span_hi, span;
  logic                   empty;
  logic [RemW-1:0]        rem_shift, trial;
  logic                   take;

  // Box is empty when any axis has its low above its high.
  always_comb begin
    empty = 1'b0;
    for (int a = 0; a < bbd_pkg::NUM_AXES; a++) begin
      if ($signed(low_i[a]) > $signed(high_i[a])) begin
        empty = 1'b1;
      end
    end
  end

  // Span of the axis the multiplier works on this cycle.
  always_comb begin
    case (axis_q)
      2'd0: begin
        span_lo = low_i[0];
        span_hi = high_i[0];
      end
      2'd1: begin
        span_lo = low_i[1];
        span_hi = high_i[1];
      end
      2'd2: begin
        span_lo = low_i[2];
        span_hi = high_i[2];
      end
      default: begin
        span_lo = '0;
        span_hi = '0;
      end
    endcase
    span = span_hi - span_lo;
  end

  // One root digit: bring down two radicand bits and try the next bit.
  assign rem_shift = {rem_q[RemW-3:0], acc_q[SumW-1 -: 2]};
  assign trial     = {root_q, 2'b01};
  assign take      = (rem_shift >= trial);

  // Sequencer and shared datapath.
  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    prod_d  = prod_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    root_d  = root_q;
    cnt_d   = cnt_q;
    case (state_q)
      bbd_pkg::ST_IDLE: begin
        if (start_i) begin
          axis_d  = '0;
          acc_d   = '0;
          rem_d   = '0;
          root_d  = '0;
          cnt_d   = '0;
          state_d = bbd_pkg::ST_SQUARE;
        end
      end
      bbd_pkg::ST_SQUARE: begin
        if (axis_q == 2'd0 && empty) begin
          state_d = bbd_pkg::ST_DONE;
        end else begin
          prod_d = {{COORD_WIDTH{1'b0}}, span} * {{COORD_WIDTH{1'b0}}, span};
          if (axis_q != 2'd0) begin
            acc_d = acc_q + {2'b00, prod_q};
          end
          axis_d = axis_q + 2'd1;
          if (axis_q == 2'd3) begin
            state_d = bbd_pkg::ST_ROOT;
          end
        end
      end
      bbd_pkg::ST_ROOT: begin
        rem_d  = take ? (rem_shift - trial) : rem_shift;
        root_d = {root_q[RootW-2:0], take};
        acc_d  = {acc_q[SumW-3:0], 2'b00};
        cnt_d  = cnt_q + CntW'(1);
        if (cnt_q == LastDigit) begin
          state_d = bbd_pkg::ST_DONE;
        end
      end
      bbd_pkg::ST_DONE: begin
        if (ack_i) begin
          state_d = bbd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bbd_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bbd_pkg::ST_IDLE;
      axis_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      cnt_q   <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign idle_o = (state_q == bbd_pkg::ST_IDLE);
  assign done_o = (state_q == bbd_pkg::ST_DONE);
  assign diag_o = root_q;

endmodule

[src/bounding_box_and_diagonal.sv]
// Vertices without the last flag are taken one per cycle while the diagonal unit is idle.
// A last vertex starts the diagonal unit: the multiplier squares and sums the spans,
// then the square root yields one digit per cycle; an empty box skips both steps.
// Input is not ready from a last vertex until its result enters the output register.
// Reset is asynchronous, active low; the box comes out of reset empty.
module bounding_box_and_diagonal #(
  parameter int unsigned COORD_WIDTH = bbd_pkg::COORD_WIDTH
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // Fields from bit 0: coord_x, coord_y, coord_z, zero fill.
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
  // Fields from bit 0: first_vertex.
  input  logic [0:0]                               s_axis_tuser,
  input  logic                                     s_axis_tlast,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // Fields from bit 0: min_x, max_x, min_y, max_y, min_z, max_z, diagonal,
  // zero fill.
  output logic [((7*COORD_WIDTH+1+7)/8)*8-1:0]      m_axis_tdata
);

  localparam int unsigned OutW   = ((7*COORD_WIDTH+1+7)/8)*8;
  localparam int unsigned FieldW = 7*COORD_WIDTH+1;

  logic [bbd_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] coord;
  logic [bbd_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] low, high;
  logic                                          in_fire;
  logic                                          diag_idle, diag_done, res_load, out_free;
  logic [COORD_WIDTH:0]                          diag;
  logic                                          out_valid_d, out_valid_q;
  logic [OutW-1:0]                               out_data_d, out_data_q;

  // Unpack the vertex beat.
  for (genvar a = 0; a < bbd_pkg::NUM_AXES; a++) begin : g_coord
    assign coord[a] = s_axis_tdata[a*COORD_WIDTH +: COORD_WIDTH];
  end

  assign s_axis_tready = diag_idle;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  bbd_extents #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_extents (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .update_i(in_fire),
    .first_i (s_axis_tuser[0]),
    .coord_i (coord),
    .low_o   (low),
    .high_o  (high)
  );

  bbd_diag #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_diag (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_fire && s_axis_tlast),
    .ack_i  (out_free),
    .low_i  (low),
    .high_i (high),
    .idle_o (diag_idle),
    .done_o (diag_done),
    .diag_o (diag)
  );

  // Output register: loads a finished result once the previous beat is gone.
  assign out_free = !out_valid_q || m_axis_tready;
  assign res_load = diag_done && out_free;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_load) begin
      out_valid_d = 1'b1;
      out_data_d  = OutW'(FieldW'({diag, high[2], low[2], high[1], low[1],
                                   high[0], low[0]}));
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // A last vertex starts the diagonal unit, which stops further input.
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && s_axis_tlast |=> !s_axis_tready)
    else $error("input still ready after a last vertex");

  // The box must hold still while the diagonal is being worked out.
  a_box_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |=> $stable(low) && $stable(high))
    else $error("extents changed during diagonal computation");

  // A loaded result is offered on the next cycle.
  a_load_offers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> m_axis_tvalid)
    else $error("loaded result not offered");

endmodule
